FILE: rtl/core/bpra_pkg.sv
// Shared types and constants for the bitmap page run allocator.
`default_nettype none
package bpra_pkg;

    localparam logic       CMD_CLEAR = 1'b0;
    localparam logic       CMD_ALLOC = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_BAD_LEN  = 2'd2;

    localparam int         CFG_INDEX_W    = 2;
    localparam int         CFG_DATA_W     = 32;
    localparam logic [1:0] REG_MAP_BYTES  = 2'd0;
    localparam logic [1:0] REG_BASE_ADDR  = 2'd1;

    localparam logic [12:0] MAP_BYTES_RESET = 13'd4096;
    localparam logic [31:0] BASE_ADDR_RESET = 32'h0050_0000;
    localparam logic [7:0]  MAP_RESERVED    = 8'h80;

    typedef struct packed {
        logic       command;
        logic [3:0] run_length;
    } in_t;

    typedef struct packed {
        logic [31:0] page_address;
        logic [1:0]  status;
    } out_t;

    typedef struct packed {
        logic       clear_load;
        logic       scan_load;
        logic       sweep_en;
        logic       scan_en;
        logic       mul_en;
        logic       add_en;
        logic       res_set;
        logic [1:0] res_code;
        logic       out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_is_clear;
        logic in_len_bad;
        logic sweep_last;
        logic found;
        logic exhausted;
    } dp_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/bpra_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module bpra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                                     aclk,
    input  wire logic                                     we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/core/bpra_dp.sv
// Datapath: bitmap memory, scan and sweep counters, run check, address and result registers.
`default_nettype none
module bpra_dp #(
    parameter int MAP_DEPTH  = 4096,
    parameter int PAGE_BYTES = 4096,
    parameter int MAX_RUN    = 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire bpra_pkg::in_t                      s_data,
    input  wire logic                               cfg_we,
    input  wire logic [bpra_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [bpra_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire bpra_pkg::ctrl_cmd_t                cmd,
    output bpra_pkg::dp_stat_t                      stat,
    output bpra_pkg::out_t                          m_data
);

    localparam int AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int CW = $clog2(MAP_DEPTH + 1);
    localparam int PW = AW + 3;

    logic [12:0]     map_bytes_reg;
    logic [31:0]     base_addr_reg;
    logic [CW-1:0]   idx_reg;
    logic [CW-1:0]   lim_reg;
    logic            rd_pend_reg;
    logic [AW-1:0]   chk_idx_reg;
    logic [3:0]      len_reg;
    logic [PW-1:0]   page_reg;
    logic [31:0]     prod_reg;
    logic [31:0]     res_addr_reg;
    logic [1:0]      res_status_reg;
    bpra_pkg::out_t  out_reg;

    logic [CW-1:0]   n_in_use;
    logic            idx_below;
    logic [7:0]      rd_byte;
    logic [7:0]      mask0;
    logic            hit;
    logic [7:0]      hit_mask;
    logic [2:0]      hit_off;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [7:0]      ram_wdata;

    bpra_ram #(
        .WIDTH (8),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rd_byte)
    );

    always_comb begin
        if (32'(map_bytes_reg) > 32'(MAP_DEPTH)) begin
            n_in_use = CW'(MAP_DEPTH);
        end else begin
            n_in_use = CW'(map_bytes_reg);
        end
    end

    assign idx_below = (idx_reg < lim_reg);
    assign mask0     = 8'((16'd1 << len_reg) - 16'd1);

    always_comb begin
        logic [15:0] shifted;
        logic [4:0]  span;
        hit      = 1'b0;
        hit_mask = 8'h00;
        hit_off  = 3'd0;
        for (int p = 7; p >= 0; p--) begin
            shifted = {8'h00, mask0} << p;
            span    = 5'(p) + 5'(len_reg);
            if ((span <= 5'd8) && ((rd_byte & shifted[7:0]) == 8'h00)) begin
                hit      = 1'b1;
                hit_mask = shifted[7:0];
                hit_off  = 3'(5'd8 - span);
            end
        end
    end

    always_comb begin
        ram_we    = cmd.sweep_en || (cmd.scan_en && stat.found);
        ram_waddr = idx_reg[AW-1:0];
        ram_wdata = (idx_reg == '0) ? bpra_pkg::MAP_RESERVED : 8'h00;
        if (cmd.scan_en) begin
            ram_waddr = chk_idx_reg;
            ram_wdata = rd_byte | hit_mask;
        end
    end

    always_comb begin
        stat.in_is_clear = (s_data.command == bpra_pkg::CMD_CLEAR);
        stat.in_len_bad  = (s_data.run_length == 4'd0) ||
                           (32'(s_data.run_length) > 32'(MAX_RUN));
        stat.sweep_last  = ((CW+1)'(idx_reg) + (CW+1)'(1)) >= (CW+1)'(lim_reg);
        stat.found       = rd_pend_reg && hit;
        stat.exhausted   = !rd_pend_reg && !idx_below;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_bytes_reg <= bpra_pkg::MAP_BYTES_RESET;
            base_addr_reg <= bpra_pkg::BASE_ADDR_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                bpra_pkg::REG_MAP_BYTES: map_bytes_reg <= cfg_wdata[12:0];
                bpra_pkg::REG_BASE_ADDR: base_addr_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            lim_reg     <= CW'(MAP_DEPTH);
            rd_pend_reg <= 1'b0;
        end else begin
            if (cmd.clear_load) begin
                idx_reg <= '0;
                lim_reg <= (n_in_use == '0) ? CW'(1) : n_in_use;
            end
            if (cmd.scan_load) begin
                idx_reg     <= '0;
                lim_reg     <= n_in_use;
                rd_pend_reg <= 1'b0;
            end
            if (cmd.sweep_en) begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (cmd.scan_en) begin
                rd_pend_reg <= idx_below;
                if (idx_below) begin
                    idx_reg <= idx_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_load) begin
            len_reg <= s_data.run_length;
        end
        if (cmd.scan_en) begin
            chk_idx_reg <= idx_reg[AW-1:0];
            if (stat.found) begin
                page_reg <= {chk_idx_reg, hit_off};
            end
        end
        if (cmd.mul_en) begin
            prod_reg <= 32'(page_reg) * 32'(PAGE_BYTES);
        end
        if (cmd.add_en) begin
            res_addr_reg   <= base_addr_reg + prod_reg;
            res_status_reg <= bpra_pkg::ST_OK;
        end
        if (cmd.res_set) begin
            res_addr_reg   <= 32'd0;
            res_status_reg <= cmd.res_code;
        end
        if (cmd.out_load) begin
            out_reg.page_address <= res_addr_reg;
            out_reg.status       <= res_status_reg;
        end
    end

    assign m_data = out_reg;

endmodule
`default_nettype wire

FILE: rtl/core/bpra_ctrl.sv
// Controller: sequences reset sweep, clear, scan, address build and output handoff.
`default_nettype none
module bpra_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    input  wire bpra_pkg::dp_stat_t  stat,
    output bpra_pkg::ctrl_cmd_t      cmd
);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CLEAR = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_ADD   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_INIT: begin
                cmd.sweep_en = 1'b1;
                if (stat.sweep_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (stat.in_is_clear) begin
                        cmd.clear_load = 1'b1;
                        cmd.res_set    = 1'b1;
                        cmd.res_code   = bpra_pkg::ST_OK;
                        state_next     = S_CLEAR;
                    end else if (stat.in_len_bad) begin
                        cmd.res_set  = 1'b1;
                        cmd.res_code = bpra_pkg::ST_BAD_LEN;
                        state_next   = S_DONE;
                    end else begin
                        cmd.scan_load = 1'b1;
                        state_next    = S_SCAN;
                    end
                end
            end
            S_CLEAR: begin
                cmd.sweep_en = 1'b1;
                if (stat.sweep_last) begin
                    state_next = S_DONE;
                end
            end
            S_SCAN: begin
                cmd.scan_en = 1'b1;
                if (stat.found) begin
                    state_next = S_MUL;
                end else if (stat.exhausted) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = bpra_pkg::ST_NO_SPACE;
                    state_next   = S_DONE;
                end
            end
            S_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = S_ADD;
            end
            S_ADD: begin
                cmd.add_en = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/bitmap_page_run_allocator.sv
// Top level of the bitmap page run allocator.
// After reset the block sweeps the whole map, one byte per cycle, before it takes its
// first transaction; configuration writes are taken throughout.
// With n the value of map_bytes saturated at MAP_DEPTH, a clear sweeps the first max(n, 1)
// map bytes and a bad run length goes straight to the result. An allocation examines the
// map bytes in order until it finds a run or has examined n bytes, paced by the single
// read port of the map memory, one byte per cycle.
// One transaction is worked at a time; a finished result waits in the output register
// while the next transaction is accepted.
`default_nettype none
module bitmap_page_run_allocator #(
    parameter int MAP_DEPTH  = 4096,
    parameter int PAGE_BYTES = 4096,
    parameter int MAX_RUN    = 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire bpra_pkg::in_t                      s_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output bpra_pkg::out_t                          m_data,
    input  wire logic                               cfg_we,
    input  wire logic [bpra_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [bpra_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    bpra_pkg::ctrl_cmd_t cmd;
    bpra_pkg::dp_stat_t  stat;

    bpra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bpra_dp #(
        .MAP_DEPTH  (MAP_DEPTH),
        .PAGE_BYTES (PAGE_BYTES),
        .MAX_RUN    (MAX_RUN)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire
